/* rtl/tmh_pkg.sv */
// Package for the timeout heap scheduler: sizes, command and status codes,
// transaction structs. No dependencies.
`default_nettype none
package tmh_pkg;
	localparam int NTIMER = 8;
	localparam int MAXOUT = 8;
	localparam int SW = $clog2(NTIMER);
	localparam int PW = $clog2(NTIMER + 1);
	localparam int NW = $clog2(MAXOUT + 1);

	localparam logic [1:0] CMD_ARM = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_ADVANCE = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] ST_ARMED = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_MISMATCH = 3'd3;
	localparam logic [2:0] ST_EXPIRED = 3'd4;
	localparam logic [2:0] ST_NONE = 3'd5;

	typedef struct packed {
		logic [1:0] command;
		logic [30:0] delay_ticks;
		logic [15:0] advance_ticks;
		logic [2:0] handle;
		logic [15:0] tag;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] slot;
		logic [15:0] owner_tag;
		logic signed [31:0] lateness;
		logic due_pending;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] slot;
		logic [15:0] owner_tag;
		logic [31:0] lateness;
	} entry_t;

	typedef struct packed {
		logic push;
		entry_t entry;
		logic release_q;
		logic due;
	} qctl_t;
endpackage
`default_nettype wire

/* rtl/timeout_heap_scheduler_unit.sv */
// Timeout heap scheduler top level: heap sequencer plus result buffer.
// Steps: an arm when full finishes at once; an arm first sifts up the delayed
// entry, if any, then sets the slot; a matching cancel removes its entry and re-sifts;
// an advance removes each due root and re-sifts (one heap move per cycle).
// Results then follow one per cycle; busy stays high through the last result,
// the receiver cannot stall, and the next start is accepted in the cycle after.
// Reset (arst_n low) empties the heap, zeroes time. Depends on tmh_pkg, tmh_core, tmh_outq.
`default_nettype none
module timeout_heap_scheduler_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire tmh_pkg::req_t request,
	output logic busy,
	output logic result_valid,
	output tmh_pkg::rsp_t result
);
	import tmh_pkg::*;

	qctl_t ctl;
	logic core_busy, q_busy;

	assign busy = core_busy | q_busy;

	tmh_core u_core (
		.clk(clk), .arst_n(arst_n), .go(start && !busy), .request(request),
		.busy(core_busy), .ctl(ctl)
	);

	tmh_outq u_outq (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .busy(q_busy),
		.result_valid(result_valid), .result(result)
	);
endmodule
`default_nettype wire

/* rtl/tmh_outq.sv */
// Result buffer: collects the results of one step, then emits them with
// the step's due flag. Depends on tmh_pkg.
`default_nettype none
module tmh_outq (
	input wire logic clk,
	input wire logic arst_n,
	input wire tmh_pkg::qctl_t ctl,
	output logic busy,
	output logic result_valid,
	output tmh_pkg::rsp_t result
);
	import tmh_pkg::*;

	entry_t buf_q [MAXOUT];
	logic [NW-1:0] cnt_q;
	logic [NW-1:0] rd_q;
	logic draining_q;
	logic due_q;
	logic valid_q;
	rsp_t out_q;
	logic is_last;

	assign is_last = (rd_q + NW'(1)) == cnt_q;
	assign busy = draining_q | valid_q | ctl.release_q;
	assign result_valid = valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (ctl.push && !cnt_q[NW-1])
			buf_q[cnt_q[SW-1:0]] <= ctl.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= '0;
			draining_q <= 1'b0;
			due_q <= 1'b0;
			valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			valid_q <= 1'b0;
			if (ctl.push)
				cnt_q <= cnt_q + NW'(1);
			if (ctl.release_q) begin
				draining_q <= 1'b1;
				due_q <= ctl.due;
				rd_q <= '0;
			end else if (draining_q) begin
				valid_q <= 1'b1;
				out_q.status <= buf_q[rd_q[SW-1:0]].status;
				out_q.slot <= buf_q[rd_q[SW-1:0]].slot;
				out_q.owner_tag <= buf_q[rd_q[SW-1:0]].owner_tag;
				out_q.lateness <= buf_q[rd_q[SW-1:0]].lateness;
				out_q.due_pending <= due_q;
				out_q.last <= is_last;
				rd_q <= rd_q + NW'(1);
				if (is_last) begin
					draining_q <= 1'b0;
					cnt_q <= '0;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/tmh_core.sv */
// Heap sequencer: slot tables, heap order and one heap move per cycle.
// Depends on tmh_pkg.
`default_nettype none
module tmh_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire tmh_pkg::req_t request,
	output logic busy,
	output tmh_pkg::qctl_t ctl
);
	import tmh_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ARM_SET, S_SIFT_UP, S_SIFT_DOWN, S_DECIDE, S_REMOVE,
		S_ADV_CHECK, S_FINISH
	} state_t;

	state_t state_q, ret_q;
	logic [SW-1:0] ord_q [NTIMER];
	logic [31:0] dl_q [NTIMER];
	logic [15:0] tg_q [NTIMER];
	logic [PW-1:0] pos_q [NTIMER];
	logic [NTIMER-1:0] armed_q;
	logic [PW-1:0] count_q;
	logic dfull_q;
	logic [31:0] now_q;
	logic [NW-1:0] n_q;
	req_t req_q;
	logic [SW-1:0] v_q;
	logic [PW:0] cur_q;
	logic [PW-1:0] rem_q;

	logic [SW-1:0] root;
	logic nonempty;
	logic [PW:0] par, ch, ch2, last_pos;
	logic [SW-1:0] ord_par, ord_ch, ord_ch2, ord_sel, ord_x, s_rem;
	logic [PW:0] ch_sel;
	logic [PW-1:0] x_pos;
	logic [31:0] new_dl;
	logic [SW-1:0] s_arm;

	assign root = ord_q[0];
	assign nonempty = (count_q != '0) || dfull_q;
	assign par = (cur_q - (PW+1)'(1)) >> 1;
	assign ch = {cur_q[PW-1:0], 1'b1};
	assign ch2 = ch + (PW+1)'(1);
	assign last_pos = {1'b0, count_q} - (PW+1)'(1);
	assign ord_par = ord_q[par[SW-1:0]];
	assign ord_ch = ord_q[ch[SW-1:0]];
	assign ord_ch2 = ord_q[ch2[SW-1:0]];
	assign ch_sel = ($signed(ch) < $signed(last_pos) && dl_q[ord_ch] > dl_q[ord_ch2]) ?
		ch2 : ch;
	assign ord_sel = ord_q[ch_sel[SW-1:0]];
	assign x_pos = dfull_q ? count_q : count_q - PW'(1);
	assign ord_x = ord_q[x_pos[SW-1:0]];
	assign s_rem = ord_q[rem_q[SW-1:0]];
	assign new_dl = now_q + {1'b0, req_q.delay_ticks};
	assign s_arm = ord_q[count_q[SW-1:0]];
	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_FINISH;
			for (int i = 0; i < NTIMER; i++) begin
				ord_q[i] <= SW'(i);
				dl_q[i] <= '0;
				tg_q[i] <= '0;
				pos_q[i] <= '0;
			end
			armed_q <= '0;
			count_q <= '0;
			dfull_q <= 1'b0;
			now_q <= '0;
			n_q <= '0;
			req_q <= '0;
			v_q <= '0;
			cur_q <= '0;
			rem_q <= '0;
			ctl <= '0;
		end else begin
			ctl <= '0;
			case (state_q)
				S_IDLE: begin
					if (go) begin
						req_q <= request;
						n_q <= '0;
						case (request.command)
							CMD_ARM: begin
								if ({1'b0, count_q} + (PW+1)'(dfull_q) >= (PW+1)'(NTIMER)) begin
									ctl.push <= 1'b1;
									ctl.entry <= '{ST_FULL, 3'd0, 16'd0, 32'd0};
									state_q <= S_FINISH;
								end else if (dfull_q) begin
									count_q <= count_q + PW'(1);
									cur_q <= {1'b0, count_q};
									v_q <= ord_q[count_q[SW-1:0]];
									ret_q <= S_ARM_SET;
									state_q <= S_SIFT_UP;
								end else begin
									state_q <= S_ARM_SET;
								end
							end
							CMD_CANCEL: begin
								if (32'(request.handle) < 32'(NTIMER) &&
								    armed_q[SW'(request.handle)] &&
								    tg_q[SW'(request.handle)] == request.tag && nonempty) begin
									rem_q <= pos_q[SW'(request.handle)];
									ret_q <= S_FINISH;
									state_q <= S_REMOVE;
								end else begin
									ctl.push <= 1'b1;
									ctl.entry <= '{ST_MISMATCH, request.handle, 16'd0, 32'd0};
									state_q <= S_FINISH;
								end
							end
							CMD_ADVANCE: begin
								now_q <= now_q + 32'(request.advance_ticks);
								state_q <= S_ADV_CHECK;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ARM_SET: begin
					tg_q[s_arm] <= req_q.tag;
					dl_q[s_arm] <= new_dl;
					armed_q[s_arm] <= 1'b1;
					if (count_q != '0 && new_dl < dl_q[root]) begin
						ord_q[count_q[SW-1:0]] <= root;
						pos_q[root] <= count_q;
						ord_q[0] <= s_arm;
						pos_q[s_arm] <= '0;
					end else begin
						pos_q[s_arm] <= count_q;
					end
					dfull_q <= 1'b1;
					ctl.push <= 1'b1;
					ctl.entry <= '{ST_ARMED, 3'(s_arm), 16'd0, 32'd0};
					state_q <= S_FINISH;
				end
				S_SIFT_UP: begin
					if (cur_q != '0 && dl_q[ord_par] > dl_q[v_q]) begin
						ord_q[cur_q[SW-1:0]] <= ord_par;
						pos_q[ord_par] <= cur_q[PW-1:0];
						cur_q <= par;
					end else begin
						ord_q[cur_q[SW-1:0]] <= v_q;
						pos_q[v_q] <= cur_q[PW-1:0];
						state_q <= ret_q;
					end
				end
				S_SIFT_DOWN: begin
					if ($signed(ch) > $signed(last_pos) || dl_q[ord_sel] >= dl_q[v_q]) begin
						ord_q[cur_q[SW-1:0]] <= v_q;
						pos_q[v_q] <= cur_q[PW-1:0];
						state_q <= ret_q;
					end else begin
						ord_q[cur_q[SW-1:0]] <= ord_sel;
						pos_q[ord_sel] <= cur_q[PW-1:0];
						cur_q <= ch_sel;
					end
				end
				S_REMOVE: begin
					if (dfull_q)
						dfull_q <= 1'b0;
					else
						count_q <= count_q - PW'(1);
					armed_q[s_rem] <= 1'b0;
					ctl.push <= 1'b1;
					ctl.entry <= '{(req_q.command == CMD_CANCEL) ? ST_CANCELLED : ST_EXPIRED,
						3'(s_rem), tg_q[s_rem],
						(req_q.command == CMD_CANCEL) ? 32'd0 : dl_q[s_rem] - now_q};
					n_q <= n_q + NW'(1);
					if (rem_q != x_pos) begin
						ord_q[rem_q[SW-1:0]] <= ord_x;
						pos_q[ord_x] <= rem_q;
						ord_q[x_pos[SW-1:0]] <= s_rem;
						pos_q[s_rem] <= x_pos;
						v_q <= ord_x;
						cur_q <= {1'b0, rem_q};
						state_q <= S_DECIDE;
					end else begin
						state_q <= ret_q;
					end
				end
				S_DECIDE: begin
					if (cur_q != '0 && dl_q[ord_par] > dl_q[v_q])
						state_q <= S_SIFT_UP;
					else
						state_q <= S_SIFT_DOWN;
				end
				S_ADV_CHECK: begin
					if (n_q < NW'(MAXOUT) && !(dl_q[root] > now_q) && nonempty) begin
						rem_q <= '0;
						ret_q <= S_ADV_CHECK;
						state_q <= S_REMOVE;
					end else begin
						if (n_q == '0) begin
							ctl.push <= 1'b1;
							ctl.entry <= '{ST_NONE, 3'd0, 16'd0, 32'd0};
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					ctl.release_q <= 1'b1;
					ctl.due <= (dl_q[root] <= now_q) && nonempty;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/tmh_checker.sv */
// Port-level checks for the timeout heap scheduler, bound to the top level.
// Depends on tmh_pkg.
`default_nettype none
module tmh_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire tmh_pkg::req_t request,
	input wire logic busy,
	input wire logic result_valid,
	input wire tmh_pkg::rsp_t result
);
	import tmh_pkg::*;

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside a transaction");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid) else $error("result after last");
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid) else $error("gap in results");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.command != CMD_UNUSED |=> busy)
		else $error("accept not held");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status <= ST_NONE) else $error("bad status");
endmodule

bind timeout_heap_scheduler_unit tmh_checker u_chk (.*);
`default_nettype wire

/* sim/tb.sv */
// Testbench for timeout_heap_scheduler_unit: drives arm, cancel, advance and unused
// commands, predicts the heap timer queue results, and checks every result.
// Depends on tmh_pkg and the RTL of timeout_heap_scheduler_unit.
`timescale 1ns / 1ps

class timer_queue_board;
	logic [2:0] order[8];
	logic [31:0] deadline[8];
	logic [15:0] slot_tag[8];
	int position[8];
	bit armed[8];
	int count;
	bit delayed;
	logic [31:0] now;
	tmh_pkg::rsp_t pending[$];
	int errors;

	function void clear();
		for (int i = 0; i < 8; i++) begin
			order[i] = 3'(i);
			deadline[i] = 0;
			slot_tag[i] = 0;
			position[i] = 0;
			armed[i] = 0;
		end
		count = 0;
		delayed = 0;
		now = 0;
		pending.delete();
		errors = 0;
	endfunction

	function void place(int pos, logic [2:0] s);
		order[pos] = s;
		position[s] = pos;
	endfunction

	function void sift_up(int c);
		logic [2:0] v;
		int p;
		v = order[c];
		while (c > 0) begin
			p = (c - 1) >> 1;
			if (!(deadline[order[p]] > deadline[v])) break;
			place(c, order[p]);
			c = p;
		end
		place(c, v);
	endfunction

	function void sift_down(int p);
		int e;
		int c;
		logic [2:0] v;
		e = count - 1;
		v = order[p];
		forever begin
			c = 2 * p + 1;
			if (c > e) break;
			if (c < e && deadline[order[c]] > deadline[order[c + 1]]) c++;
			if (deadline[order[c]] >= deadline[v]) break;
			place(p, order[c]);
			p = c;
		end
		place(p, v);
	endfunction

	function bit remove_at(int e, output logic [2:0] who);
		int x;
		logic [2:0] s;
		if (count <= 0 && !delayed) return 0;
		s = order[e];
		if (delayed) begin
			x = count;
			delayed = 0;
		end else begin
			count--;
			x = count;
		end
		if (e != x) begin
			place(e, order[x]);
			place(x, s);
			if (e > 0 && deadline[order[(e - 1) >> 1]] > deadline[order[e]]) sift_up(e);
			else sift_down(e);
		end
		armed[s] = 0;
		who = s;
		return 1;
	endfunction

	function tmh_pkg::rsp_t entry(logic [2:0] st, logic [2:0] sl, logic [15:0] tg,
			logic [31:0] late);
		tmh_pkg::rsp_t r;
		r = '0;
		r.status = st;
		r.slot = sl;
		r.owner_tag = tg;
		r.lateness = late;
		return r;
	endfunction

	function void note_request(tmh_pkg::req_t q);
		tmh_pkg::rsp_t batch[$];
		logic [2:0] s;
		logic [2:0] who;
		bit due;
		if (q.command == tmh_pkg::CMD_ARM) begin
			if (count + delayed >= 8) begin
				batch.push_back(entry(tmh_pkg::ST_FULL, 0, 0, 0));
			end else begin
				if (delayed) begin
					count++;
					sift_up(count - 1);
				end
				s = order[count];
				slot_tag[s] = q.tag;
				deadline[s] = now + {1'b0, q.delay_ticks};
				armed[s] = 1;
				position[s] = count;
				if (count > 0 && deadline[s] < deadline[order[0]]) begin
					place(count, order[0]);
					place(0, s);
				end
				delayed = 1;
				batch.push_back(entry(tmh_pkg::ST_ARMED, s, 0, 0));
			end
		end else if (q.command == tmh_pkg::CMD_CANCEL) begin
			if (armed[q.handle] && slot_tag[q.handle] == q.tag
					&& remove_at(position[q.handle], who))
				batch.push_back(entry(tmh_pkg::ST_CANCELLED, who, slot_tag[who], 0));
			else
				batch.push_back(entry(tmh_pkg::ST_MISMATCH, q.handle, 0, 0));
		end else if (q.command == tmh_pkg::CMD_ADVANCE) begin
			now = now + q.advance_ticks;
			while (batch.size() < 8) begin
				if (deadline[order[0]] > now) break;
				if (!remove_at(0, who)) break;
				batch.push_back(entry(tmh_pkg::ST_EXPIRED, who, slot_tag[who],
					deadline[who] - now));
			end
			if (batch.size() == 0) batch.push_back(entry(tmh_pkg::ST_NONE, 0, 0, 0));
		end else begin
			return;
		end
		due = deadline[order[0]] <= now && (count > 0 || delayed);
		foreach (batch[k]) begin
			batch[k].due_pending = due;
			batch[k].last = (k == batch.size() - 1);
			pending.push_back(batch[k]);
		end
	endfunction

	function void check_result(tmh_pkg::rsp_t r);
		tmh_pkg::rsp_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, r);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (r.status !== e.status || r.slot !== e.slot || r.owner_tag !== e.owner_tag
				|| r.lateness !== e.lateness || r.due_pending !== e.due_pending
				|| r.last !== e.last) begin
			$display("%0t: mismatch expected %h actual %h", $time, e, r);
			errors++;
		end
	endfunction
endclass

module tb;
	import tmh_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	req_t request;
	logic busy;
	logic result_valid;
	rsp_t result;
	timer_queue_board board;
	int cycles;
	logic [15:0] live_tag[8];

	timeout_heap_scheduler_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && result_valid) board.check_result(result);
		if (cycles > 400000) begin
			$display("FAIL timeout_heap_scheduler_unit");
			$finish;
		end
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		repeat (n) @(posedge clk);
	endtask

	task automatic issue(logic [1:0] cmd, logic [30:0] dly, logic [15:0] adv,
			logic [2:0] h, logic [15:0] tg);
		req_t q;
		q.command = cmd;
		q.delay_ticks = dly;
		q.advance_ticks = adv;
		q.handle = h;
		q.tag = tg;
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 1'b1;
		request <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_request(q);
		if (q.command == CMD_ARM && board.pending[$].status == ST_ARMED)
			live_tag[board.pending[$].slot] = q.tag;
		start <= 1'b0;
		request <= '0;
		if ($urandom_range(0, 2) != 0) idle_gap();
	endtask

	task automatic random_item();
		int pick;
		logic [2:0] h;
		pick = $urandom_range(0, 19);
		h = 3'($urandom_range(0, 7));
		if (pick < 8)
			issue(CMD_ARM,
				($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 3000)),
				16'($urandom), 3'($urandom), 16'($urandom));
		else if (pick < 13)
			issue(CMD_CANCEL, 31'($urandom), 16'($urandom), h,
				($urandom_range(0, 3) == 0) ? 16'($urandom) : live_tag[h]);
		else if (pick < 19)
			issue(CMD_ADVANCE, 31'($urandom),
				($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 900)),
				3'($urandom), 16'($urandom));
		else
			issue(CMD_UNUSED, 31'($urandom), 16'($urandom), 3'($urandom), 16'($urandom));
	endtask

	initial begin
		board = new();
		board.clear();
		foreach (live_tag[i]) live_tag[i] = 0;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_ADVANCE, 0, 0, 0, 0);
		issue(CMD_CANCEL, 0, 0, 3'd7, 16'hFFFF);
		issue(CMD_ARM, 31'h7FFFFFFF, 0, 0, 16'hFFFF);
		issue(CMD_ARM, 0, 0, 0, 16'h0000);
		for (int i = 0; i < 7; i++)
			issue(CMD_ARM, 31'(10 * (7 - i) + 5), 0, 0, 16'(16'hA500 + i));
		issue(CMD_CANCEL, 0, 0, 3'd2, 16'h1234);
		issue(CMD_CANCEL, 0, 0, 3'd2, live_tag[2]);
		issue(CMD_UNUSED, 31'h7FFFFFFF, 16'hFFFF, 3'd7, 16'hFFFF);
		issue(CMD_ADVANCE, 0, 16'd200, 0, 0);
		issue(CMD_ADVANCE, 0, 16'hFFFF, 0, 0);
		issue(CMD_ADVANCE, 0, 16'hFFFF, 0, 0);
		for (int i = 0; i < 8; i++) issue(CMD_ARM, 0, 0, 0, 16'(16'h5A00 + i));
		issue(CMD_ADVANCE, 0, 0, 0, 0);

		while (board.pending.size() != 0) @(posedge clk);
		for (int i = 0; i < 80; i++) begin
			random_item();
			if (i == 40) while (board.pending.size() != 0) @(posedge clk);
		end

		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS timeout_heap_scheduler_unit");
		else
			$display("FAIL timeout_heap_scheduler_unit");
		$finish;
	end
endmodule
